FILE: sv/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the percent escape encoder.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam logic [1:0] MODE_BINARY = 2'd0;
  localparam logic [1:0] MODE_ALL    = 2'd1;
  localparam logic [1:0] MODE_TEXT   = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_LIT,
    BODY_ESC
  } body_e;

  typedef struct packed {
    logic       head;
    body_e      body;
    logic       tail;
    logic       empty_end;
    logic       last;
    logic [7:0] data;
  } cmd_t;

endpackage

FILE: sv/pee_intf.sv
// ----------------------------------------------------------------------------
// pee_intf
// Valid/ready channels of the percent escape encoder.
// ----------------------------------------------------------------------------
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_item;
  logic       end_of_string;

  modport source (output valid, output out_byte, output byte_valid, output end_of_item,
                  output end_of_string, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input end_of_item,
                input end_of_string, output ready);
endinterface

interface pee_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] escape_mode;

  modport source (output valid, output escape_mode, input ready);
  modport sink (input valid, input escape_mode, output ready);
endinterface

FILE: sv/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front
// Accepts raw bytes, classifies them and queues at most one command per item.
// ----------------------------------------------------------------------------
module pee_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pee_cfg_if.sink       cfg_ch,
  pee_in_if.sink        in_ch,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output pee_pkg::cmd_t q_cmd_o
);
  import pee_pkg::*;

  logic [1:0] escape_mode_q;
  logic       in_string_q, in_string_d;
  logic       text_stopped_q, text_stopped_d;
  logic [1:0] mode;
  logic       framed;
  logic       drop;
  logic       accept;
  cmd_t       cmd;

  function automatic logic needs_escape(input logic [1:0] m, input logic [7:0] b);
    logic special;
    logic printable;
    logic space;
    special   = (b == 8'h25) || (b == 8'h3d) || (b == 8'h26) || (b == 8'h0d) ||
                (b == 8'h0a);
    printable = (b >= 8'h20) && (b <= 8'h7e);
    space     = (b >= 8'h09) && (b <= 8'h0d);
    case (m)
      MODE_BINARY: needs_escape = special || (b == 8'h00) || (!printable && !space);
      MODE_TEXT:   needs_escape = special || (b < 8'h20) || (b == 8'h7f);
      default:     needs_escape = 1'b1;
    endcase
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = q_ready_i;
  assign accept       = in_ch.valid && q_ready_i;

  assign mode   = (escape_mode_q == MODE_SPARE) ? MODE_ALL : escape_mode_q;
  assign framed = (mode != MODE_TEXT);
  assign drop   = !framed && (text_stopped_q || (in_ch.data_byte == 8'h00));

  always_comb begin
    cmd.head      = framed && !in_string_q;
    cmd.body      = drop ? BODY_NONE :
                    (needs_escape(mode, in_ch.data_byte) ? BODY_ESC : BODY_LIT);
    cmd.tail      = in_ch.last_byte && framed;
    cmd.empty_end = in_ch.last_byte && drop;
    cmd.last      = in_ch.last_byte;
    cmd.data      = in_ch.data_byte;
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept && (cmd.head || (cmd.body != BODY_NONE) || cmd.tail ||
                               cmd.empty_end);

  always_comb begin
    in_string_d    = in_string_q;
    text_stopped_d = text_stopped_q;
    if (accept) begin
      if (in_ch.last_byte) begin
        in_string_d    = 1'b0;
        text_stopped_d = 1'b0;
      end else begin
        in_string_d    = 1'b1;
        text_stopped_d = text_stopped_q || drop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_mode_q  <= MODE_BINARY;
      in_string_q    <= 1'b0;
      text_stopped_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        escape_mode_q <= cfg_ch.escape_mode;
      end
      in_string_q    <= in_string_d;
      text_stopped_q <= text_stopped_d;
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> q_ready_i)
    else $error("command pushed into a full queue");

  a_text_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch.last_byte) |=> (!in_string_q && !text_stopped_q))
    else $error("string state kept after last byte");

  a_last_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch.last_byte) |-> q_push_o)
    else $error("last byte produced no command");

endmodule

FILE: sv/pee_queue.sv
// ----------------------------------------------------------------------------
// pee_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module pee_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pee_pkg::cmd_t push_cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pee_pkg::cmd_t pop_cmd_o
);
  import pee_pkg::*;

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

FILE: sv/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back
// Output sequencer: expands each command into head, literal or escaped body and tail, or an empty end mark.
// ----------------------------------------------------------------------------
module pee_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pee_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  pee_out_if.source     out_ch
);
  import pee_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_PCT,
    ST_HI,
    ST_LO,
    ST_LIT,
    ST_TAIL,
    ST_EMPTY
  } state_e;

  localparam logic [7:0] HEAD_BYTES [4] = '{8'h02, 8'h02, 8'h02, 8'hde};
  localparam logic [7:0] TAIL_BYTES [4] = '{8'hc8, 8'hc2, 8'hc6, 8'hc9};
  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66};

  state_e     st_q, st_d;
  logic [1:0] idx_q, idx_d;
  cmd_t       cmd_q, cmd_d;
  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       bv_q, bv_d;
  logic       eoi_q, eoi_d;
  logic       eos_q, eos_d;
  logic       advance;
  state_e     nxt;
  logic [1:0] nxt_idx;
  logic [7:0] cur_byte;
  logic       done;

  function automatic state_e after_body(input cmd_t c);
    after_body = c.tail ? ST_TAIL : ST_IDLE;
  endfunction

  function automatic state_e body_first(input cmd_t c);
    case (c.body)
      BODY_ESC: body_first = ST_PCT;
      BODY_LIT: body_first = ST_LIT;
      default:  body_first = c.tail ? ST_TAIL : (c.empty_end ? ST_EMPTY : ST_IDLE);
    endcase
  endfunction

  function automatic state_e first_state(input cmd_t c);
    first_state = c.head ? ST_HEAD : body_first(c);
  endfunction

  always_comb begin
    nxt      = ST_IDLE;
    nxt_idx  = '0;
    cur_byte = 8'h00;
    case (st_q)
      ST_HEAD: begin
        cur_byte = HEAD_BYTES[idx_q];
        if (idx_q != 2'd3) begin
          nxt     = ST_HEAD;
          nxt_idx = idx_q + 1'b1;
        end else begin
          nxt = body_first(cmd_q);
        end
      end
      ST_PCT: begin
        cur_byte = 8'h25;
        nxt      = ST_HI;
      end
      ST_HI: begin
        cur_byte = HEX_DIGITS[cmd_q.data[7:4]];
        nxt      = ST_LO;
      end
      ST_LO: begin
        cur_byte = HEX_DIGITS[cmd_q.data[3:0]];
        nxt      = after_body(cmd_q);
      end
      ST_LIT: begin
        cur_byte = cmd_q.data;
        nxt      = after_body(cmd_q);
      end
      ST_TAIL: begin
        cur_byte = TAIL_BYTES[idx_q];
        if (idx_q != 2'd3) begin
          nxt     = ST_TAIL;
          nxt_idx = idx_q + 1'b1;
        end
      end
      default: begin
        cur_byte = 8'h00;
        nxt      = ST_IDLE;
      end
    endcase
  end

  assign done    = (nxt == ST_IDLE);
  assign advance = !ov_q || out_ch.ready;

  always_comb begin
    st_d    = st_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    ov_d    = ov_q;
    ob_d    = ob_q;
    bv_d    = bv_q;
    eoi_d   = eoi_q;
    eos_d   = eos_q;
    q_pop_o = 1'b0;
    if (advance) begin
      if (st_q != ST_IDLE) begin
        ov_d  = 1'b1;
        ob_d  = cur_byte;
        bv_d  = (st_q != ST_EMPTY);
        eoi_d = done;
        eos_d = done && cmd_q.last;
        if (!done) begin
          st_d  = nxt;
          idx_d = nxt_idx;
        end else if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          st_d    = first_state(q_cmd_i);
          idx_d   = '0;
        end else begin
          st_d = ST_IDLE;
        end
      end else begin
        ov_d = 1'b0;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          st_d    = first_state(q_cmd_i);
          idx_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ob_q  <= ob_d;
    bv_q  <= bv_d;
    eoi_q <= eoi_d;
    eos_q <= eos_d;
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.out_byte      = ob_q;
  assign out_ch.byte_valid    = bv_q;
  assign out_ch.end_of_item   = eoi_q;
  assign out_ch.end_of_string = eos_q;

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !bv_q) |-> (ob_q == 8'h00 && eos_q))
    else $error("empty result carries a byte or misses the end mark");

  a_eos_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && eos_q) |-> eoi_q)
    else $error("end of string without end of item");

  a_pop_only_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (st_q == ST_IDLE || done))
    else $error("command fetched while another is still being expanded");

endmodule

FILE: sv/percent_escape_encoder.sv
// ----------------------------------------------------------------------------
// percent_escape_encoder
// Percent-escapes a byte string into lowercase hex, one result byte per transfer.
// ----------------------------------------------------------------------------
// An input transfer is taken in any cycle in which the two-entry command queue
// has room, so bytes may arrive back to back; the output side then sets the
// pace. The output stage sends one result per cycle while the output is ready;
// an item yields one byte when passed through, three when escaped, plus four head
// bytes before the first byte and four tail bytes after the last byte of a framed
// string, up to 11 in all. Input and output stall independently of each other.
module percent_escape_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  pee_cfg_if.sink   cfg_ch,
  pee_in_if.sink    in_ch,
  pee_out_if.source out_ch
);
  import pee_pkg::*;

  logic q_push;
  logic q_ready;
  logic q_valid;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  pee_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_ch    (cfg_ch),
    .in_ch     (in_ch),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  pee_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  pee_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (pop_cmd),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
